### sv/msp_pkg.sv
`default_nettype none
package msp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 3;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_IDLE = 3'd0;
  localparam logic [PhaseW-1:0] PH_H1   = 3'd1;
  localparam logic [PhaseW-1:0] PH_H2   = 3'd2;
  localparam logic [PhaseW-1:0] PH_H3   = 3'd3;
  localparam logic [PhaseW-1:0] PH_LEN  = 3'd4;
  localparam logic [PhaseW-1:0] PH_ID   = 3'd5;
  localparam logic [PhaseW-1:0] PH_DATA = 3'd6;
  localparam logic [PhaseW-1:0] PH_SUM  = 3'd7;

  // Frame status codes
  localparam logic [StatusW-1:0] ST_OK     = 3'd0;
  localparam logic [StatusW-1:0] ST_HEADER = 3'd1;
  localparam logic [StatusW-1:0] ST_LENGTH = 3'd2;
  localparam logic [StatusW-1:0] ST_ID     = 3'd3;
  localparam logic [StatusW-1:0] ST_SUM    = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HEADER_THIRD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_EXPECTED_ID   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_PAYLOAD   = 3'd4;

  // Register reset values
  localparam logic [ByteW-1:0] RST_HEADER_FIRST  = 8'd36;
  localparam logic [ByteW-1:0] RST_HEADER_SECOND = 8'd77;
  localparam logic [ByteW-1:0] RST_HEADER_THIRD  = 8'd62;
  localparam logic [ByteW-1:0] RST_EXPECTED_ID   = 8'd0;
  localparam logic [ByteW-1:0] RST_MAX_PAYLOAD   = 8'd64;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] header_third;
    logic [ByteW-1:0] expected_id;
    logic [ByteW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [ByteW-1:0]   out_byte;
    logic               is_final;
    logic [StatusW-1:0] status;
  } result_t;

endpackage
`default_nettype wire

### sv/msp_response_deframer.sv
`default_nettype none
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   kind, rx_byte
// result    out        result_valid / result_stall  out_byte, is_final, status
// config    in         cfg_write                 cfg_index, cfg_data
//
// One byte a cycle while the result is not stalled: an accepted item is
// captured in the input register and then parsed into the result register.
// Throughput is set by the single parser step. Reset clears the parser to
// idle, the registers to their defaults and both register stages to empty.
// A stalled result holds the parser; the input register fills and then
// item_stall rises.
module msp_response_deframer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          kind,
  input  wire logic [msp_pkg::ByteW-1:0]     rx_byte,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [msp_pkg::ByteW-1:0]          out_byte,
  output logic                               is_final,
  output logic [msp_pkg::StatusW-1:0]        status,
  input  wire logic                          cfg_write,
  input  wire logic [msp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [msp_pkg::ByteW-1:0]     cfg_data
);

  msp_pkg::cfg_t    cfg;
  msp_pkg::result_t res;

  logic                       held_valid;
  logic                       held_kind;
  logic [msp_pkg::ByteW-1:0]  held_byte;
  logic                       advance;
  logic                       step;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = held_valid && !advance;
  assign step       = held_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= msp_pkg::RST_HEADER_FIRST;
      cfg.header_second <= msp_pkg::RST_HEADER_SECOND;
      cfg.header_third  <= msp_pkg::RST_HEADER_THIRD;
      cfg.expected_id   <= msp_pkg::RST_EXPECTED_ID;
      cfg.max_payload   <= msp_pkg::RST_MAX_PAYLOAD;
    end else if (cfg_write) begin
      case (cfg_index)
        msp_pkg::REG_HEADER_FIRST:  cfg.header_first  <= cfg_data;
        msp_pkg::REG_HEADER_SECOND: cfg.header_second <= cfg_data;
        msp_pkg::REG_HEADER_THIRD:  cfg.header_third  <= cfg_data;
        msp_pkg::REG_EXPECTED_ID:   cfg.expected_id   <= cfg_data;
        msp_pkg::REG_MAX_PAYLOAD:   cfg.max_payload   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held_kind <= kind;
      held_byte <= rx_byte;
    end
  end

  msp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .kind    (held_kind),
    .rx_byte (held_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_byte <= res.out_byte;
      is_final <= res.is_final;
      status   <= res.status;
    end
  end

endmodule
`default_nettype wire

### sv/msp_parser.sv
`default_nettype none
module msp_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic                         kind,
  input  wire logic [msp_pkg::ByteW-1:0]    rx_byte,
  input  wire msp_pkg::cfg_t                cfg,
  output msp_pkg::result_t                  res
);

  logic [msp_pkg::PhaseW-1:0] phase, phase_next;
  logic [msp_pkg::ByteW-1:0]  bytes_left, bytes_left_next;
  logic [msp_pkg::ByteW-1:0]  running_xor, running_xor_next;
  logic [msp_pkg::ByteW-1:0]  left_dec;
  logic [msp_pkg::ByteW-1:0]  xor_in;

  assign left_dec = bytes_left - 8'd1;
  assign xor_in   = running_xor ^ rx_byte;

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    res              = '0;
    if (kind) begin
      phase_next       = msp_pkg::PH_H1;
      bytes_left_next  = '0;
      running_xor_next = '0;
    end else begin
      case (phase)
        msp_pkg::PH_H1: begin
          if (rx_byte != cfg.header_first) begin
            res.emit     = 1'b1;
            res.is_final = 1'b1;
            res.status   = msp_pkg::ST_HEADER;
          end else begin
            phase_next = msp_pkg::PH_H2;
          end
        end
        msp_pkg::PH_H2: begin
          if (rx_byte != cfg.header_second) begin
            res.emit     = 1'b1;
            res.is_final = 1'b1;
            res.status   = msp_pkg::ST_HEADER;
          end else begin
            phase_next = msp_pkg::PH_H3;
          end
        end
        msp_pkg::PH_H3: begin
          if (rx_byte != cfg.header_third) begin
            res.emit     = 1'b1;
            res.is_final = 1'b1;
            res.status   = msp_pkg::ST_HEADER;
          end else begin
            phase_next = msp_pkg::PH_LEN;
          end
        end
        msp_pkg::PH_LEN: begin
          if (rx_byte > cfg.max_payload) begin
            res.emit     = 1'b1;
            res.is_final = 1'b1;
            res.status   = msp_pkg::ST_LENGTH;
          end else begin
            bytes_left_next  = rx_byte;
            running_xor_next = rx_byte;
            phase_next       = msp_pkg::PH_ID;
          end
        end
        msp_pkg::PH_ID: begin
          if (rx_byte != cfg.expected_id) begin
            res.emit     = 1'b1;
            res.is_final = 1'b1;
            res.status   = msp_pkg::ST_ID;
          end else begin
            running_xor_next = xor_in;
            phase_next = (bytes_left == '0) ? msp_pkg::PH_SUM : msp_pkg::PH_DATA;
          end
        end
        msp_pkg::PH_DATA: begin
          running_xor_next = xor_in;
          bytes_left_next  = left_dec;
          if (left_dec == '0) begin
            phase_next = msp_pkg::PH_SUM;
          end
          res.emit     = 1'b1;
          res.out_byte = rx_byte;
        end
        msp_pkg::PH_SUM: begin
          res.emit     = 1'b1;
          res.is_final = 1'b1;
          res.status   = (rx_byte == running_xor) ? msp_pkg::ST_OK : msp_pkg::ST_SUM;
        end
        default: begin
          // Idle: the byte is dropped.
        end
      endcase
      // Every status item returns the parser to idle.
      if (res.is_final) begin
        phase_next       = msp_pkg::PH_IDLE;
        bytes_left_next  = '0;
        running_xor_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= msp_pkg::PH_IDLE;
      bytes_left  <= '0;
      running_xor <= '0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
    end
  end

endmodule
`default_nettype wire

### sv/msp_checker.sv
`default_nettype none
module msp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          result_valid,
  input wire logic                          result_stall,
  input wire logic [msp_pkg::ByteW-1:0]     out_byte,
  input wire logic                          is_final,
  input wire logic [msp_pkg::StatusW-1:0]   status
);

  // A stalled result transfer keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte)
      && $stable(is_final) && $stable(status))
    else $error("stalled result changed");

  // Payload bytes always carry a clean status.
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_final |-> status == msp_pkg::ST_OK)
    else $error("payload byte with nonzero status");

  // The status item carries no byte and a defined code.
  a_final_fmt: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_final |-> out_byte == '0 && status <= msp_pkg::ST_SUM)
    else $error("malformed status item");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result present after reset");

endmodule

bind msp_response_deframer msp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .out_byte     (out_byte),
  .is_final     (is_final),
  .status       (status)
);
`default_nettype wire
